// ===== design/sphere_trigger_edge_detector_top_defines.svh =====
// Assertion macros for the port-level checker file
`ifndef SPHERE_TRIGGER_EDGE_DETECTOR_TOP_DEFINES_SVH
`define SPHERE_TRIGGER_EDGE_DETECTOR_TOP_DEFINES_SVH
// Implication checked on every clock edge, held off during reset
`define STD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every clock edge, held off during reset
`define STD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/sted_pkg.sv =====
package sted_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 23;
  localparam int unsigned IdW    = 16;
  localparam int unsigned CntW   = 5;
  // squared distance sum width: three 25-bit differences squared
  localparam int unsigned SqW    = 52;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    K_ADDED    = 3'd0,
    K_FULL     = 3'd1,
    K_REMOVED  = 3'd2,
    K_NOTFOUND = 3'd3,
    K_ENTER    = 3'd4,
    K_EXIT     = 3'd5,
    K_DONE     = 3'd6,
    K_QUERY    = 3'd7
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIND,
    ST_SHIFT,
    ST_RD,
    ST_DX,
    ST_DY,
    ST_DZ,
    ST_RR,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic [RadW-1:0]          radius;
    logic [IdW-1:0]           trigger_id;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [IdW-1:0]  result_id;
    logic            inside_res;
    logic [CntW-1:0] live_count;
    logic            last;
  } out_beat_t;

  // operand select for the shared squaring unit
  typedef enum logic [1:0] {
    SQ_X,
    SQ_Y,
    SQ_Z,
    SQ_R
  } sq_sel_t;

endpackage

// ===== design/sted_sq_unit.sv =====
// Shared squaring unit: one 25x25 square per cycle while en is high, registered,
// with an accumulator for the distance sum.
module sted_sq_unit (
  input  logic                          clk,
  input  logic                          en,
  input  logic                          clr,
  input  logic signed [sted_pkg::CoordW:0] opnd,
  output logic [sted_pkg::SqW-1:0]      acc_r,
  output logic [sted_pkg::SqW-1:0]      sq_r
);

  logic signed [2*sted_pkg::CoordW+1:0] sq_s;
  logic [2*sted_pkg::CoordW+1:0]        sq_full;
  logic [sted_pkg::SqW-1:0]             acc_nxt;

  // full-width signed product, never negative
  assign sq_s    = opnd * opnd;
  assign sq_full = unsigned'(sq_s);

  // accumulate previous square while producing the next
  always_comb begin
    acc_nxt = acc_r;
    if (clr) begin
      acc_nxt = '0;
    end else if (en) begin
      acc_nxt = acc_r + sq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sted_pkg::SqW'(sq_full);
    end
    acc_r <= acc_nxt;
  end

endmodule

// ===== design/sphere_trigger_edge_detector_top.sv =====
// Sphere trigger enter/exit detector.
// Input channel: in_beat is taken at a clock edge with start high and busy
// low. Result channel: each result beat sits on out_beat for one cycle with
// out_valid high; out_beat.last marks the final beat of an input. The
// receiver cannot stall, so no result is ever held back.
// Work per command, with n live triggers:
//   add                 : one beat
//   query               : one entry searched at a time (read, then compare)
//                         until the id is found or all n entries are checked
//   remove              : the same search, then each later entry is read and
//                         copied down one place
//   position update     : one beat per changed flag, then a done beat (one
//                         shared squarer does x, y, z and the radius in turn
//                         for every trigger)
// busy stays high until the last beat of an input has gone out, so the next
// command is taken only after that beat.
// Reset (synchronous, rst_n low) empties the table, clears all inside
// flags and sets the next id to one.
module sphere_trigger_edge_detector_top #(
  parameter int MAX_TRIGGERS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sted_pkg::in_beat_t   in_beat,
  output logic                 out_valid,
  output sted_pkg::out_beat_t  out_beat
);

  localparam int IdxW = (MAX_TRIGGERS > 1) ? $clog2(MAX_TRIGGERS) : 1;
  localparam int NW   = $clog2(MAX_TRIGGERS + 1);

  // table storage
  logic signed [sted_pkg::CoordW-1:0] cx_mem [MAX_TRIGGERS];
  logic signed [sted_pkg::CoordW-1:0] cy_mem [MAX_TRIGGERS];
  logic signed [sted_pkg::CoordW-1:0] cz_mem [MAX_TRIGGERS];
  logic [sted_pkg::RadW-1:0]          rad_mem [MAX_TRIGGERS];
  logic [sted_pkg::IdW-1:0]           id_mem [MAX_TRIGGERS];
  logic [MAX_TRIGGERS-1:0]            ins_r, ins_nxt;

  sted_pkg::state_t   state_r, state_nxt;
  sted_pkg::in_beat_t req_r, req_nxt;
  logic [NW-1:0]      cnt_r, cnt_nxt;
  logic [NW-1:0]      idx_r, idx_nxt;
  logic [sted_pkg::IdW-1:0] nid_r, nid_nxt;
  logic               ov_r, ov_nxt;
  sted_pkg::out_beat_t ob_r, ob_nxt;

  // registered entry read
  logic signed [sted_pkg::CoordW-1:0] rx_r, ry_r, rz_r;
  logic [sted_pkg::RadW-1:0]          rr_r;
  logic [sted_pkg::IdW-1:0]           rid_r;
  logic [IdxW-1:0] ridx;
  logic [IdxW-1:0] widx;
  logic            wr_add, wr_shift;

  // squaring unit
  logic signed [sted_pkg::CoordW:0] opnd;
  logic                             sq_en, sq_clr;
  logic [sted_pkg::SqW-1:0]         acc, sq;
  logic [sted_pkg::SqW-1:0]         d2_r, d2_nxt;

  assign ridx = idx_r[IdxW-1:0];

  sted_sq_unit u_sq (
    .clk (clk), .en (sq_en), .clr (sq_clr), .opnd (opnd), .acc_r (acc), .sq_r (sq)
  );

  // memory writes and registered read
  always_ff @(posedge clk) begin
    if (wr_add) begin
      cx_mem[widx]  <= req_r.pos_x;
      cy_mem[widx]  <= req_r.pos_y;
      cz_mem[widx]  <= req_r.pos_z;
      rad_mem[widx] <= req_r.radius;
      id_mem[widx]  <= nid_r;
    end else if (wr_shift) begin
      cx_mem[widx]  <= rx_r;
      cy_mem[widx]  <= ry_r;
      cz_mem[widx]  <= rz_r;
      rad_mem[widx] <= rr_r;
      id_mem[widx]  <= rid_r;
    end
    rx_r  <= cx_mem[ridx];
    ry_r  <= cy_mem[ridx];
    rz_r  <= cz_mem[ridx];
    rr_r  <= rad_mem[ridx];
    rid_r <= id_mem[ridx];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    nid_nxt   = nid_r;
    ins_nxt   = ins_r;
    d2_nxt    = d2_r;
    ov_nxt    = 1'b0;
    ob_nxt    = ob_r;
    wr_add    = 1'b0;
    wr_shift  = 1'b0;
    widx      = cnt_r[IdxW-1:0];
    sq_en     = 1'b0;
    sq_clr    = 1'b0;
    opnd      = '0;
    case (state_r)
      sted_pkg::ST_IDLE: begin
        // last result beat still showing keeps busy high
        if (start && !ov_r) begin
          req_nxt = in_beat;
          idx_nxt = '0;
          case (sted_pkg::opcode_t'(in_beat.opcode))
            sted_pkg::OP_ADD:    state_nxt = sted_pkg::ST_SHIFT;
            sted_pkg::OP_UPDATE: state_nxt = sted_pkg::ST_RD;
            default:             state_nxt = sted_pkg::ST_FIND;
          endcase
        end
      end
      // add completes here when the opcode is add; otherwise shift step
      sted_pkg::ST_SHIFT: begin
        if (req_r.opcode == sted_pkg::OP_ADD) begin
          ob_nxt = '{kind: sted_pkg::K_FULL, result_id: '0, inside_res: 1'b0,
                     live_count: 5'(cnt_r), last: 1'b1};
          if (32'(cnt_r) < MAX_TRIGGERS) begin
            wr_add  = 1'b1;
            ins_nxt[widx] = 1'b0;
            cnt_nxt = cnt_r + 1'b1;
            nid_nxt = nid_r + 1'b1;
            ob_nxt.kind = sted_pkg::K_ADDED;
            ob_nxt.result_id = nid_r;
            ob_nxt.live_count = 5'(cnt_r + 1'b1);
          end
          ov_nxt    = 1'b1;
          state_nxt = sted_pkg::ST_IDLE;
        end else begin
          // rx_r holds entry idx_r; copy it down one place
          widx = IdxW'(idx_r - 1'b1);
          wr_shift = 1'b1;
          ins_nxt[widx] = ins_r[ridx];
          if (idx_r + 1'b1 < cnt_r) begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = sted_pkg::ST_RD;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            ob_nxt = '{kind: sted_pkg::K_REMOVED, result_id: req_r.trigger_id,
                       inside_res: 1'b0, live_count: 5'(cnt_r - 1'b1), last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = sted_pkg::ST_IDLE;
          end
        end
      end
      // search: one entry at a time (read address, then compare)
      sted_pkg::ST_FIND: begin
        if (idx_r >= cnt_r) begin
          ob_nxt = '{kind: sted_pkg::K_QUERY, result_id: req_r.trigger_id,
                     inside_res: 1'b0, live_count: 5'(cnt_r), last: 1'b1};
          if (req_r.opcode == sted_pkg::OP_REMOVE) begin
            ob_nxt.kind = sted_pkg::K_NOTFOUND;
          end
          ov_nxt = 1'b1;
          state_nxt = sted_pkg::ST_IDLE;
        end else begin
          state_nxt = sted_pkg::ST_CMP;
        end
      end
      sted_pkg::ST_CMP: begin
        if (req_r.opcode == sted_pkg::OP_UPDATE) begin
          // d2 accumulated, sq holds r^2
          if ((d2_r <= sq) != ins_r[ridx]) begin
            ins_nxt[ridx] = (d2_r <= sq);
            ob_nxt = '{kind: (d2_r <= sq) ? sted_pkg::K_ENTER : sted_pkg::K_EXIT,
                       result_id: rid_r, inside_res: 1'b0,
                       live_count: 5'(cnt_r), last: 1'b0};
            ov_nxt = 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
          state_nxt = sted_pkg::ST_RD;
        end else if (rid_r == req_r.trigger_id) begin
          if (req_r.opcode == sted_pkg::OP_QUERY) begin
            ob_nxt = '{kind: sted_pkg::K_QUERY, result_id: req_r.trigger_id,
                       inside_res: ins_r[ridx], live_count: 5'(cnt_r), last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = sted_pkg::ST_IDLE;
          end else if (idx_r + 1'b1 < cnt_r) begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = sted_pkg::ST_RD;
          end else begin
            cnt_nxt = cnt_r - 1'b1;
            ob_nxt = '{kind: sted_pkg::K_REMOVED, result_id: req_r.trigger_id,
                       inside_res: 1'b0, live_count: 5'(cnt_r - 1'b1), last: 1'b1};
            ov_nxt = 1'b1;
            state_nxt = sted_pkg::ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = sted_pkg::ST_FIND;
        end
      end
      // read wait: remove goes to shift; update computes, or ends once all entries are done
      sted_pkg::ST_RD: begin
        if (req_r.opcode == sted_pkg::OP_REMOVE) begin
          state_nxt = sted_pkg::ST_SHIFT;
        end else if (idx_r >= cnt_r) begin
          ob_nxt = '{kind: sted_pkg::K_DONE, result_id: '0, inside_res: 1'b0,
                     live_count: 5'(cnt_r), last: 1'b1};
          ov_nxt = 1'b1;
          state_nxt = sted_pkg::ST_IDLE;
        end else begin
          state_nxt = sted_pkg::ST_DX;
        end
      end
      sted_pkg::ST_DX: begin
        sq_clr = 1'b1;
        sq_en  = 1'b1;
        opnd = (sted_pkg::CoordW+1)'(req_r.pos_x) - (sted_pkg::CoordW+1)'(rx_r);
        state_nxt = sted_pkg::ST_DY;
      end
      sted_pkg::ST_DY: begin
        sq_en = 1'b1;
        opnd = (sted_pkg::CoordW+1)'(req_r.pos_y) - (sted_pkg::CoordW+1)'(ry_r);
        state_nxt = sted_pkg::ST_DZ;
      end
      sted_pkg::ST_DZ: begin
        sq_en = 1'b1;
        opnd = (sted_pkg::CoordW+1)'(req_r.pos_z) - (sted_pkg::CoordW+1)'(rz_r);
        state_nxt = sted_pkg::ST_RR;
      end
      sted_pkg::ST_RR: begin
        sq_en = 1'b1;
        opnd = $signed({2'b00, rr_r});
        d2_nxt = acc + sq;
        state_nxt = sted_pkg::ST_CMP;
      end
      default: state_nxt = sted_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sted_pkg::ST_IDLE;
      cnt_r   <= '0;
      nid_r   <= 16'd1;
      ins_r   <= '0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      nid_r   <= nid_nxt;
      ins_r   <= ins_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
    end
    req_r <= req_nxt;
    ob_r  <= ob_nxt;
    d2_r  <= d2_nxt;
  end

  assign busy      = (state_r != sted_pkg::ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_beat  = ob_r;

endmodule

// ===== design/sted_checker.sv =====
`include "sphere_trigger_edge_detector_top_defines.svh"
// Port-level checks, bound to the top level
module sted_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input sted_pkg::out_beat_t out_beat
);

  `STD_ASSERT_NXT(a_busy_after_take, start && !busy, busy, "busy not raised after beat taken")
  `STD_ASSERT_IMP(a_busy_with_out, out_valid, busy, "result shown while not busy")
  `STD_ASSERT_IMP(a_count_range, out_valid, out_beat.live_count <= 5'd16, "live count too big")
  `STD_ASSERT_IMP(a_last_kind, out_valid && !out_beat.last,
    out_beat.kind == sted_pkg::K_ENTER || out_beat.kind == sted_pkg::K_EXIT,
    "non-final beat of wrong kind")

endmodule

bind sphere_trigger_edge_detector_top sted_checker u_sted_checker (
  .clk (clk), .rst_n (rst_n), .start (start), .busy (busy),
  .out_valid (out_valid), .out_beat (out_beat)
);

// ===== tb/sv/sted_result_checker.sv =====
// Watches both channels, models the trigger table and compares result beats
module sted_result_checker #(
  parameter int MAX_TRIGGERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  sted_pkg::in_beat_t  in_beat,
  input  logic                out_valid,
  input  sted_pkg::out_beat_t out_beat,
  output int                  fail_count,
  output int                  pending
);

  // model of the trigger table
  logic signed [sted_pkg::CoordW-1:0] cx [MAX_TRIGGERS];
  logic signed [sted_pkg::CoordW-1:0] cy [MAX_TRIGGERS];
  logic signed [sted_pkg::CoordW-1:0] cz [MAX_TRIGGERS];
  logic [sted_pkg::RadW-1:0]          rad_tab [MAX_TRIGGERS];
  logic [sted_pkg::IdW-1:0]           id_tab [MAX_TRIGGERS];
  logic                               in_flag [MAX_TRIGGERS];
  int                                 live;
  logic [sted_pkg::IdW-1:0]           next_id;

  sted_pkg::out_beat_t beats_due [$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // append one expected beat at the tail
  task automatic queue_beat(input sted_pkg::out_beat_t b);
    beats_due.insert(beats_due.size(), b);
  endtask

  function automatic sted_pkg::out_beat_t mk(sted_pkg::kind_t k,
                                             logic [sted_pkg::IdW-1:0] id,
                                             logic ins, logic lst);
    sted_pkg::out_beat_t b;
    b.kind = k; b.result_id = id; b.inside_res = ins;
    b.live_count = live[sted_pkg::CntW-1:0]; b.last = lst;
    return b;
  endfunction

  function automatic int find_id(logic [sted_pkg::IdW-1:0] id);
    for (int i = 0; i < live; i++) if (id_tab[i] == id) return i;
    return -1;
  endfunction

  function automatic logic [sted_pkg::SqW+1:0] sq(logic signed [sted_pkg::CoordW:0] d);
    logic signed [2*sted_pkg::CoordW+1:0] p;
    p = d * d;
    return p;
  endfunction

  // predict the beats of one accepted command
  task automatic predict_beats(input sted_pkg::in_beat_t c);
    int idx;
    logic [sted_pkg::SqW+1:0] d2, r2;
    logic now_in;
    case (sted_pkg::opcode_t'(c.opcode))
      sted_pkg::OP_ADD: begin
        if (live >= MAX_TRIGGERS) queue_beat(mk(sted_pkg::K_FULL, '0, 1'b0, 1'b1));
        else begin
          cx[live] = c.pos_x; cy[live] = c.pos_y; cz[live] = c.pos_z;
          rad_tab[live] = c.radius; id_tab[live] = next_id; in_flag[live] = 1'b0;
          live++;
          queue_beat(mk(sted_pkg::K_ADDED, next_id, 1'b0, 1'b1));
          next_id++;
        end
      end
      sted_pkg::OP_REMOVE: begin
        idx = find_id(c.trigger_id);
        if (idx < 0) queue_beat(mk(sted_pkg::K_NOTFOUND, c.trigger_id, 1'b0, 1'b1));
        else begin
          for (int i = idx; i + 1 < live; i++) begin
            cx[i] = cx[i+1]; cy[i] = cy[i+1]; cz[i] = cz[i+1];
            rad_tab[i] = rad_tab[i+1]; id_tab[i] = id_tab[i+1]; in_flag[i] = in_flag[i+1];
          end
          live--;
          queue_beat(mk(sted_pkg::K_REMOVED, c.trigger_id, 1'b0, 1'b1));
        end
      end
      sted_pkg::OP_QUERY: begin
        idx = find_id(c.trigger_id);
        queue_beat(mk(sted_pkg::K_QUERY, c.trigger_id, idx < 0 ? 1'b0 : in_flag[idx],
                      1'b1));
      end
      default: begin
        for (int i = 0; i < live; i++) begin
          d2 = sq({c.pos_x[sted_pkg::CoordW-1], c.pos_x} - {cx[i][sted_pkg::CoordW-1], cx[i]})
             + sq({c.pos_y[sted_pkg::CoordW-1], c.pos_y} - {cy[i][sted_pkg::CoordW-1], cy[i]})
             + sq({c.pos_z[sted_pkg::CoordW-1], c.pos_z} - {cz[i][sted_pkg::CoordW-1], cz[i]});
          r2 = rad_tab[i] * rad_tab[i];
          now_in = (d2 <= r2);
          if (now_in != in_flag[i]) begin
            in_flag[i] = now_in;
            queue_beat(mk(now_in ? sted_pkg::K_ENTER : sted_pkg::K_EXIT, id_tab[i],
                          1'b0, 1'b0));
          end
        end
        queue_beat(mk(sted_pkg::K_DONE, '0, 1'b0, 1'b1));
      end
    endcase
  endtask

  // sample both channels at the clock edge
  always @(posedge clk) begin
    sted_pkg::out_beat_t exp_b;
    if (!rst_n) begin
      live = 0; next_id = 1; fail_count = 0;
      for (int i = 0; i < MAX_TRIGGERS; i++) in_flag[i] = 1'b0;
      beats_due.delete();
    end else begin
      if (out_valid) begin
        if (beats_due.size() == 0) report_mismatch("result beat with none expected");
        else begin
          exp_b = beats_due.pop_front();
          if (out_beat.kind !== exp_b.kind)
            report_mismatch($sformatf("kind %0d want %0d", out_beat.kind, exp_b.kind));
          if (out_beat.result_id !== exp_b.result_id)
            report_mismatch($sformatf("id %0d want %0d", out_beat.result_id, exp_b.result_id));
          if (out_beat.inside_res !== exp_b.inside_res)
            report_mismatch($sformatf("inside %b want %b", out_beat.inside_res,
                                      exp_b.inside_res));
          if (out_beat.live_count !== exp_b.live_count)
            report_mismatch($sformatf("count %0d want %0d", out_beat.live_count,
                                      exp_b.live_count));
          if (out_beat.last !== exp_b.last)
            report_mismatch($sformatf("last %b want %b", out_beat.last, exp_b.last));
        end
      end
      if (start && !busy) predict_beats(in_beat);
    end
    pending = beats_due.size();
  end

endmodule

// ===== tb/sv/sphere_trigger_edge_detector_top_test.sv =====
// Stimulus and verdict for the sphere trigger detector
module sphere_trigger_edge_detector_top_test;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  sted_pkg::in_beat_t       in_beat = '0;
  logic                     out_valid;
  sted_pkg::out_beat_t      out_beat;
  int                       fail_count;
  int                       pending;
  int                       cycles = 0;
  int                       gap_pct = 9;
  int                       n_sent = 0;
  logic [sted_pkg::IdW-1:0] id_hint = sted_pkg::IdW'(1);

  always #5 clk = ~clk;

  sphere_trigger_edge_detector_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat)
  );

  sted_result_checker CHK (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .fail_count(fail_count),
    .pending(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("sphere_trigger_edge_detector_top_test: FAIL");
      $finish;
    end
  end

  // one command beat: random idle gap, then hold start until taken
  task automatic send_beat(input sted_pkg::in_beat_t b);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      in_beat <= '0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // drop start after the last beat of a run of commands
  task automatic go_idle();
    start <= 1'b0;
    in_beat <= '0;
  endtask

  function automatic sted_pkg::in_beat_t mk_cmd(sted_pkg::opcode_t op, int x, int y, int z,
                                                int r, int id);
    sted_pkg::in_beat_t b;
    b.opcode = op;
    b.pos_x = sted_pkg::CoordW'(x);
    b.pos_y = sted_pkg::CoordW'(y);
    b.pos_z = sted_pkg::CoordW'(z);
    b.radius = sted_pkg::RadW'(r);
    b.trigger_id = sted_pkg::IdW'(id);
    return b;
  endfunction

  // random command, biased to small coordinates so that updates cross spheres
  function automatic sted_pkg::in_beat_t rnd_cmd();
    sted_pkg::in_beat_t b;
    int sel;
    sel = $urandom_range(99);
    b = '0;
    if ($urandom_range(9) == 0) begin
      b.pos_x = sted_pkg::CoordW'($urandom);
      b.pos_y = sted_pkg::CoordW'($urandom);
      b.pos_z = sted_pkg::CoordW'($urandom);
      b.radius = sted_pkg::RadW'($urandom);
    end else begin
      b.pos_x = sted_pkg::CoordW'(int'($urandom_range(2000)) - 1000);
      b.pos_y = sted_pkg::CoordW'(int'($urandom_range(2000)) - 1000);
      b.pos_z = sted_pkg::CoordW'(int'($urandom_range(2000)) - 1000);
      b.radius = sted_pkg::RadW'($urandom_range(900));
    end
    b.trigger_id = ($urandom_range(3) == 0) ? sted_pkg::IdW'($urandom)
                 : sted_pkg::IdW'(id_hint - sted_pkg::IdW'($urandom_range(20)));
    if (sel < 30) b.opcode = sted_pkg::OP_ADD;
    else if (sel < 45) b.opcode = sted_pkg::OP_REMOVE;
    else if (sel < 85) b.opcode = sted_pkg::OP_UPDATE;
    else b.opcode = sted_pkg::OP_QUERY;
    return b;
  endfunction

  task automatic drain();
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  initial begin
    sted_pkg::in_beat_t b;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table cases, extremes, enter and exit
    send_beat(mk_cmd(sted_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
    send_beat(mk_cmd(sted_pkg::OP_QUERY, 0, 0, 0, 0, 16'hffff));
    send_beat(mk_cmd(sted_pkg::OP_REMOVE, 0, 0, 0, 0, 5));
    send_beat(mk_cmd(sted_pkg::OP_ADD, -8388608, -8388608, -8388608, 8388607, 0));
    send_beat(mk_cmd(sted_pkg::OP_ADD, 8388607, 8388607, 8388607, 0, 0));
    send_beat(mk_cmd(sted_pkg::OP_ADD, 0, 0, 0, 256, 0));
    send_beat(mk_cmd(sted_pkg::OP_UPDATE, 8388607, 8388607, 8388607, 0, 0));
    send_beat(mk_cmd(sted_pkg::OP_UPDATE, 256, 0, 0, 0, 0));
    send_beat(mk_cmd(sted_pkg::OP_QUERY, 0, 0, 0, 0, 3));
    send_beat(mk_cmd(sted_pkg::OP_UPDATE, -8388608, -8388608, -8388608, 0, 0));
    send_beat(mk_cmd(sted_pkg::OP_REMOVE, 0, 0, 0, 0, 2));
    send_beat(mk_cmd(sted_pkg::OP_QUERY, 0, 0, 0, 0, 2));
    for (int i = 0; i < 16; i++) send_beat(mk_cmd(sted_pkg::OP_ADD, i * 64, 0, 0, 100, 0));
    send_beat(mk_cmd(sted_pkg::OP_UPDATE, 0, 0, 0, 0, 0));
    id_hint = sted_pkg::IdW'(18);

    // hold off until the table has settled
    go_idle();
    drain();

    // random phases: light sender idling, heavy idling, then none
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
      for (int j = 0; j < 40; j++) begin
        b = rnd_cmd();
        if (b.opcode == sted_pkg::OP_ADD) id_hint++;
        send_beat(b);
      end
    end

    go_idle();
    drain();
    repeat (120) @(posedge clk);
    $display("sent %0d command beats: empty and full table, extreme coordinates,",
             n_sent);
    $display("then random mixes under light, heavy and no sender idling");
    if (fail_count == 0 && pending == 0) begin
      $display("sphere_trigger_edge_detector_top_test: PASS");
    end else begin
      $display("sphere_trigger_edge_detector_top_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sted_pkg.sv
design/sted_sq_unit.sv
design/sphere_trigger_edge_detector_top.sv
design/sted_checker.sv
tb/sv/sted_result_checker.sv
tb/sv/sphere_trigger_edge_detector_top_test.sv
